### sv/nhfc_pkg.sv
package nhfc_pkg;

  // Result kinds carried on the output tuser field
  localparam logic [3:0] KIND_DATA         = 4'd0;
  localparam logic [3:0] KIND_FRAME_OK     = 4'd1;
  localparam logic [3:0] KIND_BAD_PREAMBLE = 4'd2;
  localparam logic [3:0] KIND_BAD_LCS      = 4'd3;
  localparam logic [3:0] KIND_BAD_DIR      = 4'd4;
  localparam logic [3:0] KIND_CMD_MISMATCH = 4'd5;
  localparam logic [3:0] KIND_BAD_DCS      = 4'd6;
  localparam logic [3:0] KIND_BAD_POST     = 4'd7;
  localparam logic [3:0] KIND_LEN_SHORT    = 4'd8;

  // Frame constants
  localparam logic [7:0] PREAMBLE_ZERO  = 8'h00;
  localparam logic [7:0] START_CODE     = 8'hFF;
  localparam logic [7:0] DIR_TO_HOST    = 8'hD5;
  localparam logic [7:0] POSTAMBLE      = 8'h00;
  localparam logic [7:0] MIN_FRAME_LEN  = 8'd2;

  localparam logic [3:0] NO_ERROR = 4'd0;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] expected_command;
  } nhfc_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic [3:0] result_kind;
    logic       frame_end;
  } nhfc_result_t;

endpackage

### sv/nfc_host_frame_checker.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] rx_byte, tdata[15:8] expected_command
// m_axis   | out       | tdata payload_byte, tuser result_kind, tlast frame_end
//
// Each received byte passes an input register, one step of the frame parser and an
// output register; one byte per cycle is sustained while the output is not stalled.
// The parser's phase and checksum registers advance once per consumed byte.
// rst is synchronous, active high; it drops any byte in flight and restarts the
// parser at the first preamble byte.
// A stalled output holds the input register; the input keeps flowing while the
// output register drains in the same cycle.
module nfc_host_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] expected_command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic [3:0]  m_axis_tuser,   // [3:0] result_kind
  output logic        m_axis_tlast    // frame_end
);

  logic                   in_valid;
  nhfc_pkg::nhfc_item_t   in_item;
  nhfc_pkg::nhfc_result_t step_result;
  logic                   advance;

  // Move the held byte through the parser when the output register can take
  // whatever it produces.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register: hold the byte until the parser consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.rx_byte          <= s_axis_tdata[7:0];
      in_item.expected_command <= s_axis_tdata[15:8];
    end
  end

  nhfc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (step_result)
  );

  // Output register: load a new result, or drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step_result.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_result.valid) begin
      m_axis_tdata <= step_result.payload_byte;
      m_axis_tuser <= step_result.result_kind;
      m_axis_tlast <= step_result.frame_end;
    end
  end

endmodule

### sv/nhfc_parser.sv
module nhfc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  nhfc_pkg::nhfc_item_t  item,
  output nhfc_pkg::nhfc_result_t result
);

  typedef enum logic [3:0] {
    PH_PRE0     = 4'd0,
    PH_PRE1     = 4'd1,
    PH_START    = 4'd2,
    PH_LEN      = 4'd3,
    PH_LCS      = 4'd4,
    PH_DIR      = 4'd5,
    PH_RSP      = 4'd6,
    PH_PAYLOAD  = 4'd7,
    PH_DCS      = 4'd8,
    PH_POST_OK  = 4'd9,
    PH_POST_BAD = 4'd10
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  // header error code during the header, payload count afterwards
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] latched_command, latched_command_next;

  logic [7:0] b;
  logic [3:0] hdr_err;
  logic [3:0] rsp_err;
  logic [7:0] payload_count;
  logic [7:0] remaining;

  assign b       = item.rx_byte;
  assign hdr_err = bytes_left[3:0];

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    bytes_left_next      = bytes_left;
    running_sum_next     = running_sum;
    latched_command_next = latched_command;
    result               = '0;
    rsp_err              = hdr_err;
    payload_count        = frame_length - nhfc_pkg::MIN_FRAME_LEN;
    remaining            = bytes_left - 8'd1;

    case (phase)
      PH_PRE0: begin
        latched_command_next = item.expected_command;
        bytes_left_next = (b != nhfc_pkg::PREAMBLE_ZERO) ?
                          {4'd0, nhfc_pkg::KIND_BAD_PREAMBLE} : 8'd0;
        phase_next = PH_PRE1;
      end
      PH_PRE1: begin
        if (b != nhfc_pkg::PREAMBLE_ZERO && hdr_err == nhfc_pkg::NO_ERROR) begin
          bytes_left_next = {4'd0, nhfc_pkg::KIND_BAD_PREAMBLE};
        end
        phase_next = PH_START;
      end
      PH_START: begin
        if (b != nhfc_pkg::START_CODE && hdr_err == nhfc_pkg::NO_ERROR) begin
          bytes_left_next = {4'd0, nhfc_pkg::KIND_BAD_PREAMBLE};
        end
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        frame_length_next = b;
        phase_next = PH_LCS;
      end
      PH_LCS: begin
        if ((frame_length + b) != 8'd0 && hdr_err == nhfc_pkg::NO_ERROR) begin
          bytes_left_next = {4'd0, nhfc_pkg::KIND_BAD_LCS};
        end
        phase_next = PH_DIR;
      end
      PH_DIR: begin
        if (b != nhfc_pkg::DIR_TO_HOST && hdr_err == nhfc_pkg::NO_ERROR) begin
          bytes_left_next = {4'd0, nhfc_pkg::KIND_BAD_DIR};
        end
        running_sum_next = b;
        phase_next = PH_RSP;
      end
      PH_RSP: begin
        // a command of FF expects 100, which never matches a byte
        if ({1'b0, b} != ({1'b0, latched_command} + 9'd1) &&
            rsp_err == nhfc_pkg::NO_ERROR) begin
          rsp_err = nhfc_pkg::KIND_CMD_MISMATCH;
        end
        if (frame_length < nhfc_pkg::MIN_FRAME_LEN && rsp_err == nhfc_pkg::NO_ERROR) begin
          rsp_err = nhfc_pkg::KIND_LEN_SHORT;
        end
        running_sum_next = running_sum + b;
        if (rsp_err != nhfc_pkg::NO_ERROR) begin
          result.valid       = 1'b1;
          result.result_kind = rsp_err;
          result.frame_end   = 1'b1;
          bytes_left_next    = 8'd0;
          phase_next         = PH_PRE0;
        end else begin
          bytes_left_next = payload_count;
          phase_next = (payload_count != 8'd0) ? PH_PAYLOAD : PH_DCS;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next    = running_sum + b;
        bytes_left_next     = remaining;
        result.valid        = 1'b1;
        result.payload_byte = b;
        result.result_kind  = nhfc_pkg::KIND_DATA;
        if (remaining == 8'd0) begin
          phase_next = PH_DCS;
        end
      end
      PH_DCS: begin
        phase_next = ((running_sum + b) == 8'd0) ? PH_POST_OK : PH_POST_BAD;
      end
      PH_POST_OK: begin
        result.valid       = 1'b1;
        result.frame_end   = 1'b1;
        result.result_kind = (b != nhfc_pkg::POSTAMBLE) ?
                             nhfc_pkg::KIND_BAD_POST : nhfc_pkg::KIND_FRAME_OK;
        phase_next = PH_PRE0;
      end
      PH_POST_BAD: begin
        result.valid       = 1'b1;
        result.frame_end   = 1'b1;
        result.result_kind = nhfc_pkg::KIND_BAD_DCS;
        phase_next = PH_PRE0;
      end
      default: begin
        phase_next = PH_PRE0;
      end
    endcase

    if (!step) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_PRE0;
      frame_length    <= 8'd0;
      bytes_left      <= 8'd0;
      running_sum     <= 8'd0;
      latched_command <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      frame_length    <= frame_length_next;
      bytes_left      <= bytes_left_next;
      running_sum     <= running_sum_next;
      latched_command <= latched_command_next;
    end
  end

endmodule

### sim/tb_nfc_host_frame_checker.sv
module tb_nfc_host_frame_checker;

  // Run limits: the watchdog bound covers every byte waiting out the longest
  // sender gap and receiver stall, plus the long hold-off, several times over.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LATENCY_PAUSE = 4;
  localparam int RANDOM_ITEMS  = 160;
  localparam int HOLD_OFF      = 300;

  // Corruptions that the frame builder can apply, one bit each
  localparam int FLT_PREAMBLE  = 1;
  localparam int FLT_LCS       = 2;
  localparam int FLT_DIR       = 4;
  localparam int FLT_RSP       = 8;
  localparam int FLT_SHORT     = 16;
  localparam int FLT_DCS       = 32;
  localparam int FLT_POST      = 64;
  localparam int HEADER_FAULTS = FLT_PREAMBLE | FLT_LCS | FLT_DIR | FLT_RSP | FLT_SHORT;

  // Position of the parser inside a frame
  typedef enum logic [3:0] {
    AT_PRE0, AT_PRE1, AT_START, AT_LEN, AT_LCS, AT_DIR, AT_RSP,
    AT_PAYLOAD, AT_DCS, AT_POST_OK, AT_POST_BAD
  } frame_pos_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] kind;
    logic       last;
  } parser_out_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] rx_byte, [15:8] expected_command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] payload_byte
  logic [3:0]  m_axis_tuser;   // [3:0] result_kind
  logic        m_axis_tlast;   // frame_end

  nfc_host_frame_checker uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow of the parser state
  frame_pos_t  at_pos;
  logic [7:0]  fr_len;
  logic [7:0]  fr_left;
  logic [7:0]  fr_sum;
  logic [7:0]  fr_cmd;
  logic [3:0]  hdr_fault;

  // Results predicted but not yet seen on the output
  parser_out_t due_outputs[$];
  parser_out_t oldest;

  // Idle controls shared between the stimulus and the receiver
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_cycles;
  int rx_burst;

  int fail_count;
  int items_sent;
  int cycle_count;
  int data_seen;
  int frames_ok;
  int frames_rejected;

  // Keep only the first header error, so the earliest byte wins
  function void note_fault(input logic [3:0] code);
    if (hdr_fault == nhfc_pkg::NO_ERROR)
      hdr_fault = code;
  endfunction

  // Advance the shadow parser by one accepted byte and queue what it emits
  function void parse_rx_byte(input logic [7:0] b, input logic [7:0] cmd);
    parser_out_t r;
    r = '0;
    case (at_pos)
      AT_PRE0: begin
        fr_cmd = cmd;
        hdr_fault = nhfc_pkg::NO_ERROR;
        if (b != nhfc_pkg::PREAMBLE_ZERO) note_fault(nhfc_pkg::KIND_BAD_PREAMBLE);
        at_pos = AT_PRE1;
      end
      AT_PRE1: begin
        if (b != nhfc_pkg::PREAMBLE_ZERO) note_fault(nhfc_pkg::KIND_BAD_PREAMBLE);
        at_pos = AT_START;
      end
      AT_START: begin
        if (b != nhfc_pkg::START_CODE) note_fault(nhfc_pkg::KIND_BAD_PREAMBLE);
        at_pos = AT_LEN;
      end
      AT_LEN: begin
        fr_len = b;
        at_pos = AT_LCS;
      end
      AT_LCS: begin
        if (8'(fr_len + b) != 8'd0) note_fault(nhfc_pkg::KIND_BAD_LCS);
        at_pos = AT_DIR;
      end
      AT_DIR: begin
        if (b != nhfc_pkg::DIR_TO_HOST) note_fault(nhfc_pkg::KIND_BAD_DIR);
        fr_sum = b;
        at_pos = AT_RSP;
      end
      AT_RSP: begin
        // Compare one bit wider: a command of FF can never be answered
        if ({1'b0, b} != {1'b0, fr_cmd} + 9'd1) note_fault(nhfc_pkg::KIND_CMD_MISMATCH);
        if (fr_len < nhfc_pkg::MIN_FRAME_LEN) note_fault(nhfc_pkg::KIND_LEN_SHORT);
        fr_sum = fr_sum + b;
        if (hdr_fault != nhfc_pkg::NO_ERROR) begin
          r.kind = hdr_fault;
          r.last = 1'b1;
          due_outputs.push_back(r);
          at_pos = AT_PRE0;
        end else begin
          fr_left = fr_len - nhfc_pkg::MIN_FRAME_LEN;
          at_pos = (fr_left != 8'd0) ? AT_PAYLOAD : AT_DCS;
        end
      end
      AT_PAYLOAD: begin
        fr_sum = fr_sum + b;
        fr_left = fr_left - 8'd1;
        if (fr_left == 8'd0) at_pos = AT_DCS;
        r.data = b;
        r.kind = nhfc_pkg::KIND_DATA;
        due_outputs.push_back(r);
      end
      AT_DCS: begin
        at_pos = (8'(fr_sum + b) == 8'd0) ? AT_POST_OK : AT_POST_BAD;
      end
      default: begin
        // Postamble byte: a bad checksum takes precedence over the postamble
        if (at_pos == AT_POST_BAD)
          r.kind = nhfc_pkg::KIND_BAD_DCS;
        else
          r.kind = (b != nhfc_pkg::POSTAMBLE) ? nhfc_pkg::KIND_BAD_POST :
                                                nhfc_pkg::KIND_FRAME_OK;
        r.last = 1'b1;
        due_outputs.push_back(r);
        at_pos = AT_PRE0;
      end
    endcase
  endfunction

  // Offer one byte, hold it until accepted, then drop valid at the next falling edge
  task automatic send_byte(input logic [7:0] rx, input logic [7:0] cmd);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = 16'($urandom);
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {cmd, rx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_rx_byte(rx, cmd);
    items_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [7:0] nonzero_flip();
    return 8'($urandom_range(1, 255));
  endfunction

  // Build one response frame with random payload and the requested corruptions.
  // A frame whose header will be rejected stops after its seven header bytes.
  task automatic send_frame(input logic [7:0] cmd, input int plen, input int faults);
    logic [7:0] frame_bytes[$];
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] dcs;
    logic [7:0] post;
    bit         header_bad;
    len = ((faults & FLT_SHORT) != 0) ? 8'($urandom_range(0, 1)) : 8'(plen + 2);
    frame_bytes = {nhfc_pkg::PREAMBLE_ZERO, nhfc_pkg::PREAMBLE_ZERO,
                   nhfc_pkg::START_CODE, len, 8'(8'd0 - len),
                   nhfc_pkg::DIR_TO_HOST, 8'(cmd + 8'd1)};
    if ((faults & FLT_PREAMBLE) != 0)
      frame_bytes[$urandom_range(0, 2)] ^= nonzero_flip();
    if ((faults & FLT_LCS) != 0) frame_bytes[4] ^= nonzero_flip();
    if ((faults & FLT_DIR) != 0) frame_bytes[5] ^= nonzero_flip();
    if ((faults & FLT_RSP) != 0) frame_bytes[6] ^= nonzero_flip();
    header_bad = ((faults & HEADER_FAULTS) != 0) || (cmd == 8'hFF);
    if (!header_bad) begin
      sum = frame_bytes[5] + frame_bytes[6];
      repeat (plen) begin
        b = 8'($urandom);
        sum = sum + b;
        frame_bytes.push_back(b);
      end
      dcs = 8'd0 - sum;
      if ((faults & FLT_DCS) != 0) dcs ^= nonzero_flip();
      post = nhfc_pkg::POSTAMBLE;
      if ((faults & FLT_POST) != 0) post = nonzero_flip();
      frame_bytes.push_back(dcs);
      frame_bytes.push_back(post);
    end
    // expected_command only matters on the first byte; randomize it elsewhere
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], (i == 0) ? cmd : 8'($urandom));
  endtask

  // Pause the sender until every predicted result has come out, then let the
  // pipeline settle in case a byte without a result is still inside
  task automatic wait_drain();
    while (due_outputs.size() != 0) @(negedge clk);
    repeat (LATENCY_PAUSE) @(negedge clk);
  endtask

  task automatic test_clean_frames();
    send_frame(8'h00, 0, 0);
    send_frame(8'hFE, 3, 0);
    send_frame(8'h7F, 1, 0);
    send_frame(8'h4A, 253, 0);
  endtask

  task automatic test_header_faults();
    send_frame(8'($urandom_range(0, 254)), 2, FLT_PREAMBLE);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_PREAMBLE);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_PREAMBLE);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_LCS);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_DIR);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_RSP);
    // Command FF: no response byte can match
    send_frame(8'hFF, 2, 0);
    // Several errors at once: the earliest byte must be reported
    send_frame(8'($urandom_range(0, 254)), 2, FLT_PREAMBLE | FLT_LCS | FLT_DIR);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_LCS | FLT_DIR | FLT_RSP);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_DIR | FLT_RSP);
  endtask

  task automatic test_short_lengths();
    repeat (4) send_frame(8'($urandom_range(0, 254)), 0, FLT_SHORT);
    // A command mismatch outranks a short length
    send_frame(8'($urandom_range(0, 254)), 0, FLT_SHORT | FLT_RSP);
  endtask

  task automatic test_checksum_and_postamble();
    send_frame(8'($urandom_range(0, 254)), 4, FLT_DCS);
    send_frame(8'($urandom_range(0, 254)), 0, FLT_DCS);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_POST);
    // Bad checksum hides a bad postamble
    send_frame(8'($urandom_range(0, 254)), 3, FLT_DCS | FLT_POST);
  endtask

  // Stall the receiver long enough for the block to fill and push back on its input
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_cycles = HOLD_OFF;
    repeat (6) send_frame(8'($urandom_range(0, 254)), 8, 0);
    wait_drain();
    tx_idle_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, some corrupted, some raw noise
  task automatic test_random_traffic();
    int first;
    int pick;
    int size_pick;
    int plen;
    int faults;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      size_pick = $urandom_range(0, 99);
      if (size_pick < 90) plen = $urandom_range(0, 10);
      else if (size_pick < 98) plen = $urandom_range(11, 60);
      else plen = $urandom_range(61, 253);
      if (pick < 60) begin
        send_frame(8'($urandom), plen, 0);
      end else if (pick < 85) begin
        faults = 1 << $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) faults |= $urandom_range(1, 127);
        send_frame(8'($urandom), plen, faults);
      end else begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom), 8'($urandom));
        // Resync: finish whatever frame the noise left open
        while (at_pos != AT_PRE0) send_byte(8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Full rate on both sides to close the run
  task automatic test_no_idle_tail();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (6) send_frame(8'($urandom_range(0, 254)), $urandom_range(0, 10), 0);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_DCS);
    send_frame(8'($urandom_range(0, 254)), 2, FLT_DIR);
  endtask

  // Receiver: long hold-off first, then random stall bursts, else always ready
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_cycles--;
      end else if (rx_burst > 0) begin
        m_axis_tready = 1'b0;
        rx_burst--;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        rx_burst = $urandom_range(0, 11);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_outputs.size() == 0) begin
        $error("unexpected result: payload_byte %02h result_kind %0d frame_end %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        oldest = due_outputs.pop_front();
        if (m_axis_tdata !== oldest.data) begin
          $error("payload_byte: expected %02h, actual %02h", oldest.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== oldest.kind) begin
          $error("result_kind: expected %0d, actual %0d", oldest.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== oldest.last) begin
          $error("frame_end: expected %0b, actual %0b", oldest.last, m_axis_tlast);
          fail_count++;
        end
        if (oldest.kind == nhfc_pkg::KIND_DATA) data_seen++;
        else if (oldest.kind == nhfc_pkg::KIND_FRAME_OK) frames_ok++;
        else frames_rejected++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_outputs.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int spins;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_cycles = 0;
    rx_burst = 0;
    fail_count = 0;
    items_sent = 0;
    cycle_count = 0;
    data_seen = 0;
    frames_ok = 0;
    frames_rejected = 0;
    at_pos = AT_PRE0;
    fr_len = '0;
    fr_left = '0;
    fr_sum = '0;
    fr_cmd = '0;
    hdr_fault = nhfc_pkg::NO_ERROR;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_clean_frames();
    test_header_faults();
    test_short_lengths();
    test_checksum_and_postamble();
    test_backpressure();
    test_random_traffic();
    test_no_idle_tail();

    spins = 0;
    while (due_outputs.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    if (due_outputs.size() != 0) begin
      $error("%0d predicted results never arrived", due_outputs.size());
      fail_count++;
    end
    repeat (2 * LATENCY_PAUSE) @(negedge clk);

    $display("Sent %0d bytes; saw %0d payload bytes, %0d good frames, %0d rejected frames",
             items_sent, data_seen, frames_ok, frames_rejected);
    $display("Exercised every header and trailer error, short lengths and back-pressure");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
